// ----- rtl/core/gtg_pkg.sv -----
// ----------------------------------------------------------------------------
// gtg_pkg
// Types, constants and tables shared by the go-to-goal controller files.
// ----------------------------------------------------------------------------
`default_nettype none

package gtg_pkg;

  // Default iteration count of the shared CORDIC stage
  localparam int CORDIC_STEPS_DEF = 16;

  // Field widths
  localparam int POS_W  = 16;
  localparam int HEAD_W = 15;
  localparam int GAIN_W = 16;
  localparam int CMD_W  = 16;
  localparam int ST_W   = 2;

  // Internal widths
  localparam int XY_W   = 28;   // CORDIC x/y
  localparam int Z_W    = 21;   // CORDIC angle, Q16
  localparam int EV_W   = 17;   // position error
  localparam int ERR_W  = 17;   // bearing error, Q4.12
  localparam int DIST_W = 15;   // distance, Q5.10, non-negative
  localparam int MA_W   = 34;   // multiplier operand a
  localparam int MB_W   = 19;   // multiplier operand b
  localparam int PROD_W = 53;
  localparam int ACC_W  = 38;
  localparam int IDX_W  = 5;    // CORDIC step index (up to 32 steps)

  // Fixed point constants
  localparam int PI_Q12         = 12868;
  localparam int TWO_PI_Q12     = 25736;
  localparam int HALF_PI_Q12    = 6434;
  localparam int HALF_PI_Q16    = 102944;
  localparam int INV_GAIN_Q16   = 39797;
  localparam int LIM_LOW        = 307;
  localparam int LIM_HIGH       = 10957;
  localparam int DIST_TOL       = 10;
  localparam int ANGLE_TOL      = 71;
  localparam int ANGLE_INT_GATE = 357;
  localparam int ONE_Q10        = 1024;
  localparam int DIST_INT_CAP   = 2048;
  localparam int CMD_MAX        = 32767;
  localparam int CMD_MIN        = -32768;

  // APB register map
  localparam int NUM_REGS = 8;
  localparam int ADDR_W   = 5;
  typedef enum logic [2:0] {
    REG_KPD  = 3'd0,
    REG_KPA  = 3'd1,
    REG_KID  = 3'd2,
    REG_KIA  = 3'd3,
    REG_KDL  = 3'd4,
    REG_KDA  = 3'd5,
    REG_GX   = 3'd6,
    REG_GY   = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    ST_MOVING  = 2'd0,
    ST_ARRIVED = 2'd1,
    ST_OOB     = 2'd2
  } status_e;

  // Datapath operations issued by the sequencer
  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_LOAD   = 4'd1,
    OP_VPRE   = 4'd2,
    OP_VITER  = 4'd3,
    OP_MAGMUL = 4'd4,
    OP_ERR    = 4'd5,
    OP_CPRE   = 4'd6,
    OP_CITER  = 4'd7,
    OP_MUL1   = 4'd8,
    OP_MUL2   = 4'd9,
    OP_DINT   = 4'd10,
    OP_AINT   = 4'd11,
    OP_LIN1   = 4'd12,
    OP_LIN2   = 4'd13,
    OP_ANG1   = 4'd14,
    OP_ANG2   = 4'd15
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic             emit;
  } cmd_t;

  typedef struct packed {
    logic early;   // goal out of bounds or already arrived
  } sts_t;

  typedef struct packed {
    logic [GAIN_W-1:0]       kpd;
    logic [GAIN_W-1:0]       kpa;
    logic [GAIN_W-1:0]       kid;
    logic [GAIN_W-1:0]       kia;
    logic [GAIN_W-1:0]       kdl;
    logic [GAIN_W-1:0]       kda;
    logic signed [POS_W-1:0] gx;
    logic signed [POS_W-1:0] gy;
  } cfg_t;

  // atan(2^-i) in Q16
  function automatic logic [15:0] atan_lut(input logic [IDX_W-1:0] i);
    logic [15:0] v;
    unique case (i)
      5'd0:    v = 16'd51472;
      5'd1:    v = 16'd30386;
      5'd2:    v = 16'd16055;
      5'd3:    v = 16'd8150;
      5'd4:    v = 16'd4091;
      5'd5:    v = 16'd2047;
      5'd6:    v = 16'd1024;
      5'd7:    v = 16'd512;
      5'd8:    v = 16'd256;
      5'd9:    v = 16'd128;
      5'd10:   v = 16'd64;
      5'd11:   v = 16'd32;
      5'd12:   v = 16'd16;
      5'd13:   v = 16'd8;
      5'd14:   v = 16'd4;
      5'd15:   v = 16'd2;
      5'd16:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gtg_in_if.sv -----
// ----------------------------------------------------------------------------
// gtg_in_if
// Pose sample channel: valid/ready handshake with the pose word.
// ----------------------------------------------------------------------------
`default_nettype none

interface gtg_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [gtg_pkg::POS_W-1:0]     pos_x;
  logic signed [gtg_pkg::POS_W-1:0]     pos_y;
  logic signed [gtg_pkg::HEAD_W-1:0]    heading;
  logic                                 start_of_run;

  modport source (output valid, pos_x, pos_y, heading, start_of_run, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, start_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gtg_out_if.sv -----
// ----------------------------------------------------------------------------
// gtg_out_if
// Command channel: valid/ready handshake with the command word.
// ----------------------------------------------------------------------------
`default_nettype none

interface gtg_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [gtg_pkg::CMD_W-1:0]  linear_cmd;
  logic signed [gtg_pkg::CMD_W-1:0]  angular_cmd;
  logic [gtg_pkg::ST_W-1:0]          status;

  modport source (output valid, linear_cmd, angular_cmd, status, input ready);
  modport sink   (input valid, linear_cmd, angular_cmd, status, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gtg_cfg.sv -----
// ----------------------------------------------------------------------------
// gtg_cfg
// APB register file holding gains, damping factors and the goal position.
// ----------------------------------------------------------------------------
`default_nettype none

module gtg_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gtg_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output gtg_pkg::cfg_t                    cfg_o
);

  gtg_pkg::cfg_t cfg_q;
  gtg_pkg::reg_e sel;
  logic          wr_en;

  assign sel    = gtg_pkg::reg_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (sel)
        gtg_pkg::REG_KPD: cfg_q.kpd <= pwdata[15:0];
        gtg_pkg::REG_KPA: cfg_q.kpa <= pwdata[15:0];
        gtg_pkg::REG_KID: cfg_q.kid <= pwdata[15:0];
        gtg_pkg::REG_KIA: cfg_q.kia <= pwdata[15:0];
        gtg_pkg::REG_KDL: cfg_q.kdl <= pwdata[15:0];
        gtg_pkg::REG_KDA: cfg_q.kda <= pwdata[15:0];
        gtg_pkg::REG_GX:  cfg_q.gx  <= $signed(pwdata[15:0]);
        gtg_pkg::REG_GY:  cfg_q.gy  <= $signed(pwdata[15:0]);
        default:          cfg_q     <= cfg_q;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (sel)
      gtg_pkg::REG_KPD: prdata = {16'd0, cfg_q.kpd};
      gtg_pkg::REG_KPA: prdata = {16'd0, cfg_q.kpa};
      gtg_pkg::REG_KID: prdata = {16'd0, cfg_q.kid};
      gtg_pkg::REG_KIA: prdata = {16'd0, cfg_q.kia};
      gtg_pkg::REG_KDL: prdata = {16'd0, cfg_q.kdl};
      gtg_pkg::REG_KDA: prdata = {16'd0, cfg_q.kda};
      gtg_pkg::REG_GX:  prdata = {16'd0, cfg_q.gx};
      gtg_pkg::REG_GY:  prdata = {16'd0, cfg_q.gy};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/gtg_ctrl.sv -----
// ----------------------------------------------------------------------------
// gtg_ctrl
// Sequencer: steps the datapath through one control update per pose word.
// ----------------------------------------------------------------------------
`default_nettype none

module gtg_ctrl #(
  parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  gtg_pkg::sts_t      sts_i,
  output gtg_pkg::cmd_t      cmd_o
);

  localparam int CW = $clog2(CORDIC_STEPS);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DECIDE = 5'd1;
  localparam logic [4:0] S_VIT    = 5'd2;
  localparam logic [4:0] S_MAG    = 5'd3;
  localparam logic [4:0] S_ERR    = 5'd4;
  localparam logic [4:0] S_CPRE   = 5'd5;
  localparam logic [4:0] S_CIT    = 5'd6;
  localparam logic [4:0] S_MUL1   = 5'd7;
  localparam logic [4:0] S_MUL2   = 5'd8;
  localparam logic [4:0] S_DINT   = 5'd9;
  localparam logic [4:0] S_AINT   = 5'd10;
  localparam logic [4:0] S_LIN1   = 5'd11;
  localparam logic [4:0] S_LIN2   = 5'd12;
  localparam logic [4:0] S_ANG1   = 5'd13;
  localparam logic [4:0] S_ANG2   = 5'd14;
  localparam logic [4:0] S_DONE   = 5'd15;

  logic [4:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  logic          last;

  assign last        = (cnt_q == CW'(CORDIC_STEPS - 1));
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and command
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = gtg_pkg::OP_NONE;
    cmd_o.idx   = gtg_pkg::IDX_W'(cnt_q);
    cmd_o.emit  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = gtg_pkg::OP_LOAD;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cnt_d = '0;
        if (sts_i.early) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = gtg_pkg::OP_VPRE;
          state_d  = S_VIT;
        end
      end
      S_VIT: begin
        cmd_o.op = gtg_pkg::OP_VITER;
        cnt_d    = cnt_q + 1'b1;
        if (last) begin
          cnt_d   = '0;
          state_d = S_MAG;
        end
      end
      S_MAG: begin
        cmd_o.op = gtg_pkg::OP_MAGMUL;
        state_d  = S_ERR;
      end
      S_ERR: begin
        cmd_o.op = gtg_pkg::OP_ERR;
        state_d  = S_CPRE;
      end
      S_CPRE: begin
        cmd_o.op = gtg_pkg::OP_CPRE;
        state_d  = S_CIT;
      end
      S_CIT: begin
        cmd_o.op = gtg_pkg::OP_CITER;
        cnt_d    = cnt_q + 1'b1;
        if (last) begin
          cnt_d   = '0;
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin cmd_o.op = gtg_pkg::OP_MUL1; state_d = S_MUL2; end
      S_MUL2: begin cmd_o.op = gtg_pkg::OP_MUL2; state_d = S_DINT; end
      S_DINT: begin cmd_o.op = gtg_pkg::OP_DINT; state_d = S_AINT; end
      S_AINT: begin cmd_o.op = gtg_pkg::OP_AINT; state_d = S_LIN1; end
      S_LIN1: begin cmd_o.op = gtg_pkg::OP_LIN1; state_d = S_LIN2; end
      S_LIN2: begin cmd_o.op = gtg_pkg::OP_LIN2; state_d = S_ANG1; end
      S_ANG1: begin cmd_o.op = gtg_pkg::OP_ANG1; state_d = S_ANG2; end
      S_ANG2: begin cmd_o.op = gtg_pkg::OP_ANG2; state_d = S_DONE; end
      S_DONE: begin
        // hand the word to the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/gtg_dp.sv -----
// ----------------------------------------------------------------------------
// gtg_dp
// Datapath: shared CORDIC stage, shared multiplier, integrators and output.
// ----------------------------------------------------------------------------
`default_nettype none

module gtg_dp (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  gtg_pkg::cmd_t                           cmd_i,
  output gtg_pkg::sts_t                           sts_o,
  input  gtg_pkg::cfg_t                           cfg_i,
  input  wire logic signed [gtg_pkg::POS_W-1:0]   pos_x_i,
  input  wire logic signed [gtg_pkg::POS_W-1:0]   pos_y_i,
  input  wire logic signed [gtg_pkg::HEAD_W-1:0]  heading_i,
  input  wire logic                               start_i,
  output logic signed [gtg_pkg::CMD_W-1:0]        linear_cmd_o,
  output logic signed [gtg_pkg::CMD_W-1:0]        angular_cmd_o,
  output logic [gtg_pkg::ST_W-1:0]                status_o
);

  localparam int XY_W   = gtg_pkg::XY_W;
  localparam int Z_W    = gtg_pkg::Z_W;
  localparam int EV_W   = gtg_pkg::EV_W;
  localparam int ERR_W  = gtg_pkg::ERR_W;
  localparam int DIST_W = gtg_pkg::DIST_W;
  localparam int MA_W   = gtg_pkg::MA_W;
  localparam int MB_W   = gtg_pkg::MB_W;
  localparam int PROD_W = gtg_pkg::PROD_W;
  localparam int ACC_W  = gtg_pkg::ACC_W;
  localparam int CMD_W  = gtg_pkg::CMD_W;

  // working registers (payload)
  logic signed [EV_W-1:0]   ex_q, ex_d, ey_q, ey_d;
  logic signed [gtg_pkg::HEAD_W-1:0] hd_q, hd_d;
  logic signed [XY_W-1:0]   x_q, x_d, y_q, y_d;
  logic signed [Z_W-1:0]    z_q, z_d;
  logic                     zero_q, zero_d, neg_q, neg_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [DIST_W-1:0]        dist_q, dist_d;
  logic signed [ERR_W-1:0]  err_q, err_d;
  logic signed [CMD_W-1:0]  rlin_q, rlin_d, rang_q, rang_d;
  logic [gtg_pkg::ST_W-1:0] rst_q, rst_d;
  logic signed [CMD_W-1:0]  olin_q, oang_q;
  logic [gtg_pkg::ST_W-1:0] ost_q;

  // control state
  logic                     early_q, early_d;
  logic signed [15:0]       di_q, di_d, ai_q, ai_d, pl_q, pl_d, pa_q, pa_d;
  logic                     arr_q, arr_d;

  // shared multiplier
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;

  // scratch
  logic signed [XY_W-1:0]   dx, dy, cosv;
  logic signed [Z_W-1:0]    atan_z, bear;
  logic signed [PROD_W-1:0] pr;
  logic signed [ERR_W:0]    e0;
  logic signed [ERR_W-1:0]  ca;
  logic signed [20:0]       dsum;
  logic signed [24:0]       asum;
  logic signed [ACC_W-1:0]  t;
  logic                     oob, arr_eff;

  assign sts_o.early   = early_q;
  assign linear_cmd_o  = olin_q;
  assign angular_cmd_o = oang_q;
  assign status_o      = ost_q;

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    ex_d = ex_q; ey_d = ey_q; hd_d = hd_q;
    x_d = x_q; y_d = y_q; z_d = z_q;
    zero_d = zero_q; neg_d = neg_q;
    acc_d = acc_q; dist_d = dist_q; err_d = err_q;
    rlin_d = rlin_q; rang_d = rang_q; rst_d = rst_q;
    early_d = early_q;
    di_d = di_q; ai_d = ai_q; pl_d = pl_q; pa_d = pa_q; arr_d = arr_q;
    mul_a = '0; mul_b = '0;
    dx     = y_q >>> cmd_i.idx;
    dy     = x_q >>> cmd_i.idx;
    atan_z = $signed({{(Z_W-16){1'b0}}, gtg_pkg::atan_lut(cmd_i.idx)});
    cosv   = neg_q ? -x_q : x_q;
    pr = '0; e0 = '0; ca = '0; dsum = '0; asum = '0; t = '0; bear = '0;
    oob = (cfg_i.gx < 16'sd307) || (cfg_i.gx > 16'sd10957) ||
          (cfg_i.gy < 16'sd307) || (cfg_i.gy > 16'sd10957);
    arr_eff = start_i ? 1'b0 : arr_q;

    unique case (cmd_i.op)
      gtg_pkg::OP_NONE: ;
      // latch pose, apply start clear, settle the early answers
      gtg_pkg::OP_LOAD: begin
        ex_d = EV_W'(cfg_i.gx) - EV_W'(pos_x_i);
        ey_d = EV_W'(cfg_i.gy) - EV_W'(pos_y_i);
        hd_d = heading_i;
        if (start_i) begin
          di_d = '0; ai_d = '0; pl_d = '0; pa_d = '0; arr_d = 1'b0;
        end
        early_d = oob || arr_eff;
        rlin_d  = '0;
        rang_d  = '0;
        rst_d   = oob ? gtg_pkg::ST_OOB : gtg_pkg::ST_ARRIVED;
      end
      // vectoring setup: move left half plane into the right one
      gtg_pkg::OP_VPRE: begin
        zero_d = (ex_q == '0) && (ey_q == '0);
        x_d = XY_W'(ex_q) <<< 8;
        y_d = XY_W'(ey_q) <<< 8;
        z_d = '0;
        if (ex_q < 0) begin
          if (ey_q >= 0) begin
            x_d = XY_W'(ey_q) <<< 8;
            y_d = -(XY_W'(ex_q) <<< 8);
            z_d = Z_W'(gtg_pkg::HALF_PI_Q16);
          end else begin
            x_d = -(XY_W'(ey_q) <<< 8);
            y_d = XY_W'(ex_q) <<< 8;
            z_d = -Z_W'(gtg_pkg::HALF_PI_Q16);
          end
        end
      end
      gtg_pkg::OP_VITER: begin
        if (y_q > 0) begin
          x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + atan_z;
        end else begin
          x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - atan_z;
        end
      end
      gtg_pkg::OP_MAGMUL: begin
        mul_a = MA_W'(x_q);
        mul_b = MB_W'(gtg_pkg::INV_GAIN_Q16);
      end
      // distance and wrapped bearing error
      gtg_pkg::OP_ERR: begin
        pr = (prod_q + (PROD_W'(1) <<< 23)) >>> 24;
        if (zero_q || pr < 0)       dist_d = '0;
        else if (pr > gtg_pkg::CMD_MAX) dist_d = DIST_W'(gtg_pkg::CMD_MAX);
        else                        dist_d = pr[DIST_W-1:0];
        bear = zero_q ? Z_W'(0) : ((z_q + Z_W'(8)) >>> 4);
        e0 = (ERR_W+1)'(bear) - (ERR_W+1)'(hd_q);
        if (e0 < -gtg_pkg::PI_Q12)     e0 = e0 + (ERR_W+1)'(gtg_pkg::TWO_PI_Q12);
        else if (e0 > gtg_pkg::PI_Q12) e0 = e0 - (ERR_W+1)'(gtg_pkg::TWO_PI_Q12);
        err_d = e0[ERR_W-1:0];
      end
      // rotation setup for the cosine of the bearing error
      gtg_pkg::OP_CPRE: begin
        ca    = err_q;
        neg_d = 1'b0;
        if (err_q > gtg_pkg::HALF_PI_Q12) begin
          ca = err_q - ERR_W'(gtg_pkg::PI_Q12); neg_d = 1'b1;
        end else if (err_q < -gtg_pkg::HALF_PI_Q12) begin
          ca = err_q + ERR_W'(gtg_pkg::PI_Q12); neg_d = 1'b1;
        end
        z_d = Z_W'(ca) <<< 4;
        x_d = XY_W'(gtg_pkg::INV_GAIN_Q16);
        y_d = '0;
      end
      gtg_pkg::OP_CITER: begin
        if (z_q >= 0) begin
          x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - atan_z;
        end else begin
          x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + atan_z;
        end
      end
      gtg_pkg::OP_MUL1: begin
        mul_a = $signed({{(MA_W-16){1'b0}}, cfg_i.kid});
        mul_b = $signed({{(MB_W-DIST_W){1'b0}}, dist_q});
      end
      gtg_pkg::OP_MUL2: begin
        mul_a = $signed(prod_q[MA_W-1:0]);
        mul_b = MB_W'(cosv);
      end
      // distance integral, gated and clamped
      gtg_pkg::OP_DINT: begin
        pr   = (prod_q + (PROD_W'(1) <<< 27)) >>> 28;
        dsum = 21'(di_q);
        if (dist_q < DIST_W'(gtg_pkg::ONE_Q10)) dsum = dsum + $signed(pr[20:0]);
        if (dsum > gtg_pkg::DIST_INT_CAP)       di_d = 16'(gtg_pkg::DIST_INT_CAP);
        else if (dsum < -gtg_pkg::DIST_INT_CAP) di_d = -16'(gtg_pkg::DIST_INT_CAP);
        else                                    di_d = dsum[15:0];
        mul_a = $signed({{(MA_W-16){1'b0}}, cfg_i.kia});
        mul_b = MB_W'(err_q);
      end
      // angle integral, gated and clamped
      gtg_pkg::OP_AINT: begin
        pr   = (prod_q + (PROD_W'(1) <<< 11)) >>> 12;
        asum = 25'(ai_q);
        if (err_q < gtg_pkg::ANGLE_INT_GATE) asum = asum + $signed(pr[24:0]);
        if (asum > gtg_pkg::PI_Q12)       ai_d = 16'(gtg_pkg::PI_Q12);
        else if (asum < -gtg_pkg::PI_Q12) ai_d = -16'(gtg_pkg::PI_Q12);
        else                              ai_d = asum[15:0];
        mul_a = $signed({{(MA_W-16){1'b0}}, cfg_i.kpd});
        mul_b = $signed({{(MB_W-DIST_W){1'b0}}, dist_q});
      end
      gtg_pkg::OP_LIN1: begin
        acc_d = ACC_W'(prod_q) + (ACC_W'(di_q) <<< 12);
        mul_a = $signed({{(MA_W-16){1'b0}}, cfg_i.kdl});
        mul_b = MB_W'(pl_q);
      end
      // linear command: round and saturate
      gtg_pkg::OP_LIN2: begin
        t = (acc_q - ACC_W'(prod_q) + ACC_W'(2048)) >>> 12;
        if (t > gtg_pkg::CMD_MAX)      rlin_d = CMD_W'(gtg_pkg::CMD_MAX);
        else if (t < gtg_pkg::CMD_MIN) rlin_d = CMD_W'(gtg_pkg::CMD_MIN);
        else                           rlin_d = t[CMD_W-1:0];
        mul_a = $signed({{(MA_W-16){1'b0}}, cfg_i.kpa});
        mul_b = MB_W'(err_q);
      end
      gtg_pkg::OP_ANG1: begin
        acc_d = ACC_W'(prod_q) + (ACC_W'(ai_q) <<< 12);
        mul_a = $signed({{(MA_W-16){1'b0}}, cfg_i.kda});
        mul_b = MB_W'(pa_q);
      end
      // angular command, then the arrival test
      gtg_pkg::OP_ANG2: begin
        t = (acc_q - (ACC_W'(prod_q) <<< 2) + ACC_W'(8192)) >>> 14;
        if (t > gtg_pkg::CMD_MAX)      rang_d = CMD_W'(gtg_pkg::CMD_MAX);
        else if (t < gtg_pkg::CMD_MIN) rang_d = CMD_W'(gtg_pkg::CMD_MIN);
        else                           rang_d = t[CMD_W-1:0];
        if (dist_q <= DIST_W'(gtg_pkg::DIST_TOL) &&
            err_q <= gtg_pkg::ANGLE_TOL && err_q >= -gtg_pkg::ANGLE_TOL) begin
          arr_d  = 1'b1;
          pl_d   = '0;
          pa_d   = '0;
          rlin_d = '0;
          rang_d = '0;
          rst_d  = gtg_pkg::ST_ARRIVED;
        end else begin
          pl_d  = rlin_q;
          pa_d  = rang_d;
          rst_d = gtg_pkg::ST_MOVING;
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      early_q <= 1'b0;
      di_q    <= '0;
      ai_q    <= '0;
      pl_q    <= '0;
      pa_q    <= '0;
      arr_q   <= 1'b0;
    end else begin
      early_q <= early_d;
      di_q    <= di_d;
      ai_q    <= ai_d;
      pl_q    <= pl_d;
      pa_q    <= pa_d;
      arr_q   <= arr_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ex_q   <= ex_d;   ey_q <= ey_d;  hd_q <= hd_d;
    x_q    <= x_d;    y_q  <= y_d;   z_q  <= z_d;
    zero_q <= zero_d; neg_q <= neg_d;
    prod_q <= prod_d; acc_q <= acc_d;
    dist_q <= dist_d; err_q <= err_d;
    rlin_q <= rlin_d; rang_q <= rang_d; rst_q <= rst_d;
    if (cmd_i.emit) begin
      olin_q <= rlin_q;
      oang_q <= rang_q;
      ost_q  <= rst_q;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/go_to_goal_pi_controller.sv -----
// ----------------------------------------------------------------------------
// go_to_goal_pi_controller
// Go-to-goal PI controller for a unicycle robot, one command word per pose.
// ----------------------------------------------------------------------------
// Each pose word goes through one shared CORDIC stage, run once in vectoring
// mode for distance and bearing and once in rotation mode for the cosine,
// plus eight steps on one shared multiplier, before the next is accepted.
// When the goal is out of bounds or the robot has already arrived the
// sequencer skips straight to the output step. The result sits in an
// output register, so a finished word waiting on the sink does not hold up
// the next pose. Gains and goal are to be written over APB only while the
// block is idle; the block itself does not enforce this.
`default_nettype none

module go_to_goal_pi_controller #(
  parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  gtg_in_if.sink                           in_i,
  gtg_out_if.source                        out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gtg_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  gtg_pkg::cfg_t cfg;
  gtg_pkg::cmd_t cmd;
  gtg_pkg::sts_t sts;

  gtg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gtg_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gtg_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_i         (cfg),
    .pos_x_i       (in_i.pos_x),
    .pos_y_i       (in_i.pos_y),
    .heading_i     (in_i.heading),
    .start_i       (in_i.start_of_run),
    .linear_cmd_o  (out_o.linear_cmd),
    .angular_cmd_o (out_o.angular_cmd),
    .status_o      (out_o.status)
  );

  // out-of-bounds and arrived words carry zero commands
  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status == gtg_pkg::ST_OOB) |->
      (out_o.linear_cmd == '0) && (out_o.angular_cmd == '0))
    else $error("out of bounds word with nonzero command");

  a_arr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status == gtg_pkg::ST_ARRIVED) |->
      (out_o.linear_cmd == '0) && (out_o.angular_cmd == '0))
    else $error("arrived word with nonzero command");

  // one pose at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("second pose accepted while busy");

endmodule

`default_nettype wire

// ----- verif/gtg_checker.sv -----
// ----------------------------------------------------------------------------
// gtg_checker
// Watches the pose and command channels, predicts each command word from
// the pose words and the register shadow, and compares them field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module gtg_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  gtg_in_if.sink            in_mon,
  gtg_out_if.sink           out_mon,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [gtg_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]  pwdata,
  input  wire logic         pready,
  output int                err_cnt,
  output int                pending,
  output int                n_cmds
);
  timeunit 1ns;
  timeprecision 1ps;
  import gtg_pkg::*;

  typedef struct {
    logic signed [CMD_W-1:0] lin;
    logic signed [CMD_W-1:0] ang;
    status_e                 st;
  } cmd_word_t;

  cmd_word_t cmd_q[$];

  // shadow registers and controller state
  logic [15:0] regs [NUM_REGS];
  longint dint, aint, plin, pang;
  bit     arr;

  longint tbl [24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                       256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

  function automatic longint fl_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rhu(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint lim(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void polar(longint ex, longint ey, output longint mag,
                                output longint ang);
    longint x, y, z, t, dx, dy;
    x = ex * 256; y = ey * 256; z = 0;
    if (ex == 0 && ey == 0) begin
      mag = 0; ang = 0;
      return;
    end
    if (x < 0) begin
      if (y >= 0) begin t = x; x = y; y = -t; z = HALF_PI_Q16; end
      else begin t = x; x = -y; y = t; z = -HALF_PI_Q16; end
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = fl_shr(y, i); dy = fl_shr(x, i);
      if (y > 0) begin x += dx; y -= dy; z += tbl[i]; end
      else begin x -= dx; y += dy; z -= tbl[i]; end
    end
    mag = lim(rhu(x * INV_GAIN_Q16, 24), 0, CMD_MAX);
    ang = rhu(z, 4);
  endfunction

  function automatic longint cos_q16(longint a);
    longint x, y, z, dx, dy;
    bit neg;
    x = INV_GAIN_Q16; y = 0; neg = 0;
    if (a > HALF_PI_Q12) begin a -= PI_Q12; neg = 1; end
    else if (a < -HALF_PI_Q12) begin a += PI_Q12; neg = 1; end
    z = a * 16;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = fl_shr(y, i); dy = fl_shr(x, i);
      if (z >= 0) begin x -= dx; y += dy; z -= tbl[i]; end
      else begin x += dx; y -= dy; z += tbl[i]; end
    end
    return neg ? -x : x;
  endfunction

  function automatic bit goal_off(longint v);
    return v > LIM_HIGH || v < LIM_LOW;
  endfunction

  // next command word for one pose; updates the controller state
  function automatic cmd_word_t control_step(longint px, longint py, longint hd,
                                             bit sor);
    cmd_word_t w;
    longint gx, gy, dlen, brg, e, lin, angc, ae;
    gx = longint'($signed(regs[REG_GX]));
    gy = longint'($signed(regs[REG_GY]));
    w.lin = '0; w.ang = '0;
    if (sor) begin
      dint = 0; aint = 0; plin = 0; pang = 0; arr = 0;
    end
    if (goal_off(gx) || goal_off(gy)) begin
      w.st = ST_OOB;
      return w;
    end
    if (arr) begin
      w.st = ST_ARRIVED;
      return w;
    end
    polar(gx - px, gy - py, dlen, brg);
    e = brg - hd;
    if (e < -PI_Q12) e += TWO_PI_Q12;
    else if (e > PI_Q12) e -= TWO_PI_Q12;
    if (dlen < ONE_Q10)
      dint += rhu(longint'(regs[REG_KID]) * dlen * cos_q16(e), 28);
    if (e < ANGLE_INT_GATE)
      aint += rhu(longint'(regs[REG_KIA]) * e, 12);
    dint = lim(dint, -DIST_INT_CAP, DIST_INT_CAP);
    aint = lim(aint, -PI_Q12, PI_Q12);
    lin = rhu(longint'(regs[REG_KPD]) * dlen + dint * 4096
              - longint'(regs[REG_KDL]) * plin, 12);
    angc = rhu(longint'(regs[REG_KPA]) * e + aint * 4096
               - longint'(regs[REG_KDA]) * pang * 4, 14);
    lin = lim(lin, CMD_MIN, CMD_MAX);
    angc = lim(angc, CMD_MIN, CMD_MAX);
    ae = e < 0 ? -e : e;
    if (dlen <= DIST_TOL && ae <= ANGLE_TOL) begin
      arr = 1; plin = 0; pang = 0;
      w.st = ST_ARRIVED;
      return w;
    end
    plin = lin; pang = angc;
    w.lin = lin[15:0]; w.ang = angc[15:0]; w.st = ST_MOVING;
    return w;
  endfunction

  assign pending = cmd_q.size();

  // register writes, pose words in, command words out
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_word_t w, got;
    if (!rst_ni) begin
      foreach (regs[i]) regs[i] = '0;
      dint = 0; aint = 0; plin = 0; pang = 0; arr = 0;
      cmd_q.delete();
      err_cnt <= 0;
      n_cmds <= 0;
    end else begin
      if (psel && penable && pwrite && pready)
        regs[paddr[4:2]] = pwdata[15:0];
      if (in_mon.valid && in_mon.ready) begin
        w = control_step(longint'(in_mon.pos_x), longint'(in_mon.pos_y),
                         longint'(in_mon.heading), in_mon.start_of_run);
        cmd_q.push_back(w);
      end
      if (out_mon.valid && out_mon.ready) begin
        n_cmds <= n_cmds + 1;
        if (cmd_q.size() == 0) begin
          if (err_cnt < 10) $display("unexpected command word");
          err_cnt <= err_cnt + 1;
        end else begin
          got = cmd_q.pop_front();
          if (got.lin !== out_mon.linear_cmd || got.ang !== out_mon.angular_cmd ||
              got.st !== out_mon.status) begin
            if (err_cnt < 10)
              $display("mismatch: exp lin %0d ang %0d st %0d, got lin %0d ang %0d st %0d",
                       got.lin, got.ang, got.st, out_mon.linear_cmd,
                       out_mon.angular_cmd, out_mon.status);
            err_cnt <= err_cnt + 1;
          end
        end
      end
    end
  end
endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives pose words and APB register writes into the go-to-goal controller
// under random idling on both channels; the checker judges each command word.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gtg_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int err_cnt, pending, n_cmds;
  int src_idle = 0, snk_idle = 0;
  int n_poses = 0;

  gtg_in_if  pose_ch ();
  gtg_out_if cmd_ch ();

  go_to_goal_pi_controller dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(pose_ch.sink), .out_o(cmd_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  gtg_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_mon(pose_ch.sink), .out_mon(cmd_ch.sink),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .err_cnt(err_cnt), .pending(pending),
    .n_cmds(n_cmds)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    pose_ch.valid = 0; pose_ch.pos_x = '0; pose_ch.pos_y = '0;
    pose_ch.heading = '0; pose_ch.start_of_run = 0;
    cmd_ch.ready = 0;
  end

  // receiver stalls at random
  always @(posedge clk_i)
    cmd_ch.ready <= ($urandom_range(99) >= snk_idle);

  task automatic reg_write(reg_e r, logic [15:0] v);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_W'(r) << 2;
    pwdata <= {16'h0, v};
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // drop valid, wait until all words are back, then let the block settle
  task automatic drain();
    pose_ch.valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // valid stays up after acceptance until the next idle cycle or a drain
  task automatic send_pose(logic [15:0] x, logic [15:0] y, logic [14:0] h, bit s);
    while ($urandom_range(99) < src_idle) begin
      pose_ch.valid <= 0;
      @(posedge clk_i);
    end
    pose_ch.valid <= 1; pose_ch.pos_x <= x; pose_ch.pos_y <= y;
    pose_ch.heading <= h; pose_ch.start_of_run <= s;
    do @(posedge clk_i); while (!pose_ch.ready);
    n_poses++;
  endtask

  task automatic set_gains(logic [15:0] k0, k1, k2, k3, k4, k5, gx, gy);
    reg_write(REG_KPD, k0); reg_write(REG_KPA, k1);
    reg_write(REG_KID, k2); reg_write(REG_KIA, k3);
    reg_write(REG_KDL, k4); reg_write(REG_KDA, k5);
    reg_write(REG_GX, gx); reg_write(REG_GY, gy);
  endtask

  function automatic logic [14:0] rand_head();
    if ($urandom_range(9) == 0) return 15'($urandom);
    return 15'($signed($urandom_range(25736)) - 12868);
  endfunction

  // random run toward a goal: poses mostly within 2000 of it, sometimes within 10, or noise
  task automatic random_run(int n);
    logic [15:0] gx, gy, x, y;
    gx = 16'($urandom_range(LIM_HIGH, LIM_LOW));
    gy = 16'($urandom_range(LIM_HIGH, LIM_LOW));
    case ($urandom_range(5))
      0: gx = 16'($urandom);
      1: gy = 16'($urandom_range(LIM_LOW - 1));
      default: ;
    endcase
    drain();
    set_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom_range(8192)), 16'($urandom_range(8192)), gx, gy);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: begin x = 16'($urandom); y = 16'($urandom); end
        1, 2: begin
          x = gx + 16'($signed($urandom_range(20)) - 10);
          y = gy + 16'($signed($urandom_range(20)) - 10);
        end
        default: begin
          x = gx + 16'($signed($urandom_range(4000)) - 2000);
          y = gy + 16'($signed($urandom_range(4000)) - 2000);
        end
      endcase
      send_pose(x, y, rand_head(), i == 0 || $urandom_range(40) == 0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    src_idle = 34; snk_idle = 85;
    // directed: goal bounds, extremes, arrival, headings out of range
    set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'd306, 16'd5000);
    send_pose(16'd0, 16'd0, 15'd0, 1);
    drain();
    reg_write(REG_GX, 16'd10958);
    send_pose(16'd0, 16'd0, 15'd0, 0);
    drain();
    reg_write(REG_GX, 16'd307); reg_write(REG_GY, 16'd10957);
    send_pose(16'h8000, 16'h8000, 15'h4000, 1);
    send_pose(16'h7FFF, 16'h7FFF, 15'h3FFF, 0);
    send_pose(16'h7FFF, 16'h8000, 15'd12868, 0);
    send_pose(16'h8000, 16'h7FFF, -15'sd12868, 0);
    send_pose(16'd307, 16'd10957, 15'd0, 0);
    send_pose(16'd307, 16'd10957, 15'd0, 0);
    send_pose(16'd0, 16'd0, 15'd0, 1);
    send_pose(16'd300, 16'd10950, 15'd100, 0);
    send_pose(16'd1000, 16'd10957, 15'd12868, 0);
    send_pose(16'd307, 16'd9000, 15'd6434, 0);
    drain();
    set_gains(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'd10957, 16'd307);
    send_pose(16'd10000, 16'd300, 15'd50, 1);
    send_pose(16'd10957, 16'd307, 15'd80, 0);
    send_pose(16'd10957, 16'd307, 15'd0, 0);
    send_pose(16'd5000, 16'd307, 15'd0, 1);
    // random phases with three idling patterns
    for (int ph = 0; ph < 45; ph++) begin
      if (ph == 15) begin src_idle = 85; snk_idle = 34; end
      if (ph == 30) begin src_idle = 0; snk_idle = 0; end
      random_run(40);
    end
    drain();
    $display("sent %0d pose words over 45 goal settings, %0d command words checked",
             n_poses, n_cmds);
    if (err_cnt == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule

`default_nettype wire
